[sv/ud32_pkg.sv]
// Shared types and constants of the 32-by-16 unsigned divider.
package ud32_pkg;

  localparam int unsigned DataW         = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned NumSteps      = DataW;
  localparam int unsigned NumStages     = 4;
  localparam int unsigned StepsPerStage = NumSteps / NumStages;
  // Prep register plus one register per divide stage.
  localparam int unsigned Latency       = NumStages + 1;

  typedef struct packed {
    logic             word_mode;
    logic [DataW-1:0] dividend_high;
    logic [DataW-1:0] dividend_low;
    logic [DataW-1:0] divisor;
  } div_in_t;

  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
    logic             divide_error;
  } div_out_t;

  // Partial remainder, dividend bits shifting out the top while quotient
  // bits shift in at the bottom, and the divisor.
  typedef struct packed {
    logic             err;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] qd;
    logic [DataW-1:0] dvs;
  } div_pipe_t;

endpackage

[sv/unsigned_divide_32_by_16.sv]
// Pipelined unsigned divider, 32/16 word mode and 16/8 byte mode.
//
// Usage:
//   An operation is taken at a rising edge with start high and busy low.
//   in_i carries word_mode, dividend_high (DX), dividend_low (AX), divisor.
//   Each result appears on res_o for one cycle with done_o high; the
//   receiver cannot hold it off, and no stall path exists.
//   From the accepting edge an operation passes one prep register and
//   then four stages of four restoring steps, each a 17-bit compare
//   and subtract, to the edge that takes the result.
//   Throughput: one operation per cycle, back to back, as long as start
//   stays high and busy is low.
//   Byte mode returns quotient and remainder in bits 7..0, upper bits zero.
//   A zero divisor or a quotient too wide for the mode sets divide_error
//   with quotient and remainder zero.
//   Reset clears all valid bits, so operations in flight are dropped. busy
//   is set by reset and cleared by the clock after reset ends, then stays low.
module unsigned_divide_32_by_16 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ud32_pkg::div_in_t  in_i,
  output logic               done_o,
  output ud32_pkg::div_out_t res_o
);
  import ud32_pkg::*;

  logic      busy_q;
  logic      vld  [NumStages+1];
  div_pipe_t pipe [NumStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  ud32_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy_q),
    .in_i    (in_i),
    .valid_o (vld[0]),
    .pipe_o  (pipe[0])
  );

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    ud32_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .pipe_i  (pipe[g]),
      .valid_o (vld[g+1]),
      .pipe_o  (pipe[g+1])
    );
  end

  assign done_o             = vld[NumStages];
  assign res_o.divide_error = pipe[NumStages].err;
  assign res_o.quotient     = pipe[NumStages].err ? '0 : pipe[NumStages].qd;
  assign res_o.remainder    = pipe[NumStages].err ? '0 : pipe[NumStages].rem;

endmodule

[sv/ud32_prep.sv]
// Input stage: overflow and zero-divisor detection, operand setup.
module ud32_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ud32_pkg::div_in_t  in_i,
  output logic               valid_o,
  output ud32_pkg::div_pipe_t pipe_o
);
  import ud32_pkg::*;

  logic      valid_q;
  div_pipe_t pipe_d, pipe_q;
  logic [ByteW-1:0] dvs8;

  always_comb begin
    dvs8   = in_i.divisor[ByteW-1:0];
    pipe_d = '0;
    if (in_i.word_mode) begin
      // Quotient fits in 16 bits only when DX < divisor.
      pipe_d.err = (in_i.divisor == '0) || (in_i.dividend_high >= in_i.divisor);
      pipe_d.rem = in_i.dividend_high;
      pipe_d.qd  = in_i.dividend_low;
      pipe_d.dvs = in_i.divisor;
    end else begin
      // Byte mode runs all steps from a zero remainder; AH < divisor keeps
      // the quotient within 8 bits.
      pipe_d.err = (dvs8 == '0) || (in_i.dividend_low[DataW-1:ByteW] >= dvs8);
      pipe_d.rem = '0;
      pipe_d.qd  = in_i.dividend_low;
      pipe_d.dvs = {{(DataW-ByteW){1'b0}}, dvs8};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

[sv/ud32_stage.sv]
// One pipeline stage of restoring division steps.
module ud32_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ud32_pkg::div_pipe_t pipe_i,
  output logic                valid_o,
  output ud32_pkg::div_pipe_t pipe_o
);
  import ud32_pkg::*;

  logic       valid_q;
  div_pipe_t  pipe_d, pipe_q;
  logic [DataW:0] sh;

  always_comb begin
    pipe_d = pipe_i;
    sh     = '0;
    for (int unsigned s = 0; s < StepsPerStage; s++) begin
      sh        = {pipe_d.rem, pipe_d.qd[DataW-1]};
      pipe_d.qd = {pipe_d.qd[DataW-2:0], 1'b0};
      if (sh >= {1'b0, pipe_d.dvs}) begin
        sh           = sh - {1'b0, pipe_d.dvs};
        pipe_d.qd[0] = 1'b1;
      end
      // Remainder stays below the divisor, so the top bit is clear here.
      pipe_d.rem = sh[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

[sv/ud32_checker.sv]
// Port-level checker for the divider, bound to the top level.
module ud32_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input ud32_pkg::div_in_t  in_i,
  input logic               done_o,
  input ud32_pkg::div_out_t res_o
);
  import ud32_pkg::*;

  // Every beat taken comes out on done_o after the prep register and all stages.
  a_accept_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("accepted beat gives no result strobe");

  // No result strobe without a beat taken that has passed the prep register and all stages.
  a_done_has_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result strobe without accepted beat");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.divide_error) |-> (res_o.quotient == '0 && res_o.remainder == '0))
    else $error("divide error with nonzero results");

  a_byte_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(!in_i.word_mode, Latency))
      |-> (res_o.quotient[DataW-1:ByteW] == '0 && res_o.remainder[DataW-1:ByteW] == '0))
    else $error("byte mode result exceeds 8 bits");

  a_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(in_i.word_mode && in_i.divisor == '0, Latency))
      |-> res_o.divide_error)
    else $error("zero divisor not flagged");

endmodule

bind unsigned_divide_32_by_16 ud32_checker u_ud32_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .in_i   (in_i),
  .done_o (done_o),
  .res_o  (res_o)
);
